>>> hdl/bsap_pkg.sv
// bsap_pkg: shared types, constants and object table for the advertisement parser
// used by bsap_front, bsap_queue, bsap_back and ble_sensor_advert_parser
// no dependencies
package bsap_pkg;

   // input word: one service-data byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_last;
      logic       cmd;
   } req_type;

   // output word: one per frame
   typedef struct packed {
      logic               frame_ok;
      logic signed [19:0] temperature_centi;
      logic [7:0]         humidity_pct;
      logic               temperature_seen;
      logic               humidity_seen;
      logic [1:0]         sensor_kind;
   } rsp_type;

   // frame summary handed from front to back
   typedef struct packed {
      logic [1:0]  sensor_kind;
      logic        temp_seen;
      logic        hum_seen;
      logic [15:0] temp_raw;
      logic        temp_x10;
      logic [15:0] hum_raw;
      logic        hum_centi;
   } frame_sum_type;

   // frame format codes
   localparam logic CMD_BTHOME = 1'b0;
   localparam logic CMD_ATC    = 1'b1;

   // sensor kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BTHOME = 2'd1;
   localparam logic [1:0] KIND_ATC13  = 2'd2;
   localparam logic [1:0] KIND_ATC15  = 2'd3;

   // frame layout
   localparam logic [7:0] BTHOME_HEADER   = 8'h40;
   localparam logic [7:0] ATC_FIELD_FIRST = 8'd6;
   localparam logic [7:0] ATC_FIELD_LAST  = 8'd9;
   localparam logic [7:0] ATC13_LAST_POS  = 8'd12;
   localparam logic [7:0] ATC15_LAST_POS  = 8'd14;
   localparam logic [7:0] POS_MAX         = 8'hFF;

   // object ids of interest
   localparam logic [7:0] OBJ_TEMP_CENTI = 8'h02;
   localparam logic [7:0] OBJ_HUM_CENTI  = 8'h03;
   localparam logic [7:0] OBJ_HUM_PCT    = 8'h2E;
   localparam logic [7:0] OBJ_TEMP_DECI  = 8'h45;

   // hundredths to percent: q = (raw * 5243) >> 19, exact for raw below PCT_SAT_LIMIT
   localparam logic [28:0] PCT_RECIP      = 29'd5243;
   localparam logic [15:0] PCT_SAT_LIMIT  = 16'd25600;
   localparam logic [7:0]  PCT_SAT        = 8'hFF;

   // frame summary queue
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

   // id present in the object table
   function automatic logic obj_known(input logic [7:0] id);
      return (id inside {[8'h00:8'h2F], 8'h3A, [8'h3C:8'h53]});
   endfunction

   // table slot of a known id (ids are stored in ascending order)
   function automatic logic [6:0] obj_slot(input logic [7:0] id);
      logic [7:0] slot;
      if (id == 8'h3A) begin
         slot = 8'd48;
      end else if (id > 8'h3A) begin
         slot = id - 8'd11;
      end else begin
         slot = id;
      end
      return slot[6:0];
   endfunction

   // value length in bytes of a known id
   function automatic logic [7:0] obj_len(input logic [7:0] id);
      logic [7:0] len;
      case (id)
         8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h4B: len = 8'd3;
         8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50: len = 8'd4;
         8'h53: len = 8'd255;
         8'h02, 8'h03, 8'h06, 8'h07, 8'h08, 8'h0C, 8'h0D, 8'h0E, 8'h12, 8'h13,
         8'h14, 8'h3C, 8'h3D, 8'h3F, 8'h40, 8'h41, 8'h43, 8'h44, 8'h45, 8'h47,
         8'h48, 8'h49, 8'h4A, 8'h51, 8'h52: len = 8'd2;
         default: len = 8'd1;
      endcase
      return len;
   endfunction

endpackage

>>> hdl/bsap_front.sv
// bsap_front: byte walker, takes one frame byte per cycle and builds a frame summary
// depends on bsap_pkg; feeds bsap_queue and holds off bytes while the queue is full
module bsap_front
   import bsap_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          q_push,
   output frame_sum_type q_data,
   input  logic          q_full
);

   typedef enum logic [1:0] {
      WALK_ID,
      WALK_VALUE,
      WALK_STOP
   } walk_type;

   localparam logic [7:0] MAX_POS = 8'(MAX_FRAME_BYTES);

   walk_type    walk_ff, walk_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  skip_ff, skip_in;
   logic [7:0]  obj_id_ff, obj_id_in;
   logic        first_ff, first_in;
   logic [6:0]  last_slot_ff, last_slot_in;
   logic [7:0]  low_ff, low_in;
   logic [1:0]  flags_ff, flags_in;
   logic [15:0] pend_t_ff, pend_t_in;
   logic        pend_x10_ff, pend_x10_in;
   logic [15:0] pend_h_ff, pend_h_in;
   logic        pend_centi_ff, pend_centi_in;
   logic [7:0]  atc_ff [4];

   logic        accept;
   logic [7:0]  b;
   logic [15:0] raw;
   logic [6:0]  rom_slot;
   logic        rom_hit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign rom_hit   = obj_known(b);
   assign rom_slot  = obj_slot(b);
   assign raw       = {b, (first_ff ? b : low_ff)};

   // object walk for the current byte
   always_comb begin
      walk_in       = walk_ff;
      skip_in       = skip_ff;
      obj_id_in     = obj_id_ff;
      first_in      = first_ff;
      last_slot_in  = last_slot_ff;
      low_in        = low_ff;
      flags_in      = flags_ff;
      pend_t_in     = pend_t_ff;
      pend_x10_in   = pend_x10_ff;
      pend_h_in     = pend_h_ff;
      pend_centi_in = pend_centi_ff;
      pos_in        = (pos_ff != POS_MAX) ? pos_ff + 8'd1 : pos_ff;
      if (pos_ff < MAX_POS) begin
         if (pos_ff == 8'd0) begin
            walk_in = (b == BTHOME_HEADER) ? WALK_ID : WALK_STOP;
         end else begin
            case (walk_ff)
               WALK_ID: begin
                  if (rom_hit && (rom_slot >= last_slot_ff)) begin
                     last_slot_in = rom_slot;
                     obj_id_in    = b;
                     skip_in      = obj_len(b);
                     first_in     = 1'b1;
                     walk_in      = WALK_VALUE;
                  end else begin
                     walk_in = WALK_STOP;
                  end
               end
               WALK_VALUE: begin
                  if (first_ff) begin
                     low_in = b;
                  end
                  first_in = 1'b0;
                  skip_in  = (skip_ff != 8'd0) ? skip_ff - 8'd1 : skip_ff;
                  // object complete on its last value byte
                  if (skip_ff <= 8'd1) begin
                     walk_in = WALK_ID;
                     case (obj_id_ff)
                        OBJ_TEMP_CENTI: begin
                           pend_t_in   = raw;
                           pend_x10_in = 1'b0;
                           flags_in[0] = 1'b1;
                        end
                        OBJ_TEMP_DECI: begin
                           pend_t_in   = raw;
                           pend_x10_in = 1'b1;
                           flags_in[0] = 1'b1;
                        end
                        OBJ_HUM_CENTI: begin
                           pend_h_in     = raw;
                           pend_centi_in = 1'b1;
                           flags_in[1]   = 1'b1;
                        end
                        OBJ_HUM_PCT: begin
                           pend_h_in     = {8'd0, b};
                           pend_centi_in = 1'b0;
                           flags_in[1]   = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // frame summary on the last byte
   always_comb begin
      q_data             = '0;
      if (req_data.cmd == CMD_BTHOME) begin
         if (flags_in != 2'b00) begin
            q_data.sensor_kind = KIND_BTHOME;
            q_data.temp_seen   = flags_in[0];
            q_data.hum_seen    = flags_in[1];
            q_data.temp_raw    = pend_t_in;
            q_data.temp_x10    = pend_x10_in;
            q_data.hum_raw     = pend_h_in;
            q_data.hum_centi   = pend_centi_in;
         end
      end else if (pos_ff == ATC13_LAST_POS) begin
         q_data.sensor_kind = KIND_ATC13;
         q_data.temp_seen   = 1'b1;
         q_data.hum_seen    = 1'b1;
         q_data.temp_raw    = {atc_ff[0], atc_ff[1]};
         q_data.temp_x10    = 1'b1;
         q_data.hum_raw     = {8'd0, atc_ff[2]};
         q_data.hum_centi   = 1'b0;
      end else if (pos_ff == ATC15_LAST_POS) begin
         q_data.sensor_kind = KIND_ATC15;
         q_data.temp_seen   = 1'b1;
         q_data.hum_seen    = 1'b1;
         q_data.temp_raw    = {atc_ff[1], atc_ff[0]};
         q_data.temp_x10    = 1'b0;
         q_data.hum_raw     = {atc_ff[3], atc_ff[2]};
         q_data.hum_centi   = 1'b1;
      end
   end

   assign q_push = accept && req_data.frame_last;

   // per-frame control state, cleared after each last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= WALK_ID;
         pos_ff       <= '0;
         skip_ff      <= '0;
         obj_id_ff    <= '0;
         first_ff     <= 1'b0;
         last_slot_ff <= '0;
         flags_ff     <= '0;
      end else if (accept) begin
         if (req_data.frame_last) begin
            walk_ff      <= WALK_ID;
            pos_ff       <= '0;
            skip_ff      <= '0;
            obj_id_ff    <= '0;
            first_ff     <= 1'b0;
            last_slot_ff <= '0;
            flags_ff     <= '0;
         end else begin
            walk_ff      <= walk_in;
            pos_ff       <= pos_in;
            skip_ff      <= skip_in;
            obj_id_ff    <= obj_id_in;
            first_ff     <= first_in;
            last_slot_ff <= last_slot_in;
            flags_ff     <= flags_in;
         end
      end
   end

   // pending values and atc field capture
   always_ff @(posedge clock) begin
      if (accept) begin
         low_ff        <= low_in;
         pend_t_ff     <= pend_t_in;
         pend_x10_ff   <= pend_x10_in;
         pend_h_ff     <= pend_h_in;
         pend_centi_ff <= pend_centi_in;
         if ((pos_ff >= ATC_FIELD_FIRST) && (pos_ff <= ATC_FIELD_LAST)) begin
            atc_ff[pos_ff[1:0] - 2'd2] <= b;
         end
      end
   end

`ifndef ASSERT_OFF
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_last) |=> (pos_ff == 8'd0 && flags_ff == 2'b00))
      else $error("per-frame state not cleared after last byte");
   a_push_taken: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("summary pushed into full queue");
`endif

endmodule

>>> hdl/bsap_queue.sv
// bsap_queue: two-entry queue of frame summaries between front and back
// depends on bsap_pkg
module bsap_queue
   import bsap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_sum_type push_data,
   output logic          full,
   input  logic          pop,
   output frame_sum_type pop_data,
   output logic          empty
);

   frame_sum_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff;
   logic [QUEUE_PTR_W:0]         count_ff;

   assign full     = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

>>> hdl/bsap_back.sv
// bsap_back: scales a frame summary, updates kept values and drives the output register
// depends on bsap_pkg; fed by bsap_queue
module bsap_back
   import bsap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  frame_sum_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic signed [19:0] kept_t_ff, kept_t_in;
   logic [7:0]         kept_h_ff, kept_h_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic signed [19:0] t_ext;
   logic signed [19:0] t_scaled;
   logic [28:0]        h_prod;
   logic [7:0]         h_pct;

   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_ready);

   // temperature: sign extend, tenths to hundredths by shift-add
   assign t_ext    = {{4{q_data.temp_raw[15]}}, q_data.temp_raw};
   assign t_scaled = q_data.temp_x10 ? ((t_ext <<< 3) + (t_ext <<< 1)) : t_ext;

   // humidity: hundredths to percent by reciprocal multiply, saturated
   assign h_prod = 29'(q_data.hum_raw) * PCT_RECIP;
   always_comb begin
      if (!q_data.hum_centi) begin
         h_pct = q_data.hum_raw[7:0];
      end else if (q_data.hum_raw >= PCT_SAT_LIMIT) begin
         h_pct = PCT_SAT;
      end else begin
         h_pct = h_prod[26:19];
      end
   end

   assign kept_t_in = q_data.temp_seen ? t_scaled : kept_t_ff;
   assign kept_h_in = q_data.hum_seen ? h_pct : kept_h_ff;

   // kept values and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_t_ff    <= '0;
         kept_h_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            kept_t_ff    <= kept_t_in;
            kept_h_ff    <= kept_h_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff.frame_ok          <= (q_data.sensor_kind != KIND_NONE);
         rsp_ff.temperature_centi <= kept_t_in;
         rsp_ff.humidity_pct      <= kept_h_in;
         rsp_ff.temperature_seen  <= q_data.temp_seen;
         rsp_ff.humidity_seen     <= q_data.hum_seen;
         rsp_ff.sensor_kind       <= q_data.sensor_kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_kept_hold: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.sensor_kind == KIND_NONE) |=>
      ($stable(kept_t_ff) && $stable(kept_h_ff)))
      else $error("kept values changed on failed frame");
   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.frame_ok == (rsp_ff.sensor_kind != KIND_NONE)))
      else $error("frame_ok disagrees with sensor_kind");
`endif

endmodule

>>> hdl/ble_sensor_advert_parser.sv
// ble_sensor_advert_parser: top level of the sensor advertisement parser
// depends on bsap_pkg, bsap_front, bsap_queue, bsap_back
//
// Usage:
//   req channel: one service-data byte per word, with frame_last on the final
//   byte and cmd selecting the frame format (BTHome or ATC environmental).
//   rsp channel: one word per frame, issued for the word that carries frame_last.
//   Throughput: one byte per cycle while the queue is not full; the byte walker
//   decodes the object table combinationally, so bytes and frames enter back to back.
//   Result path: the front summary of an accepted last byte is written into the
//   queue, then popped, scaled and registered in the output register.
//   Stall: a two-word queue sits between walker and output stage; while the
//   receiver holds rsp_ready low, bytes keep flowing until the output register
//   and both queue entries hold finished frames, and then req_ready drops until
//   the receiver takes a word and a queue entry frees up.
//   Reset: synchronous; clears the walk, the queue, the output valid flag and the
//   kept temperature and humidity (both read as zero until a frame succeeds).
//   MAX_FRAME_BYTES: BTHome bytes at or beyond this position are ignored.
module ble_sensor_advert_parser
   import bsap_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   frame_sum_type q_push_data;
   frame_sum_type q_pop_data;

   // byte walker
   bsap_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   // frame summary queue
   bsap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // scaling and output stage
   bsap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/tb_ble_sensor_advert_parser.sv
// tb_ble_sensor_advert_parser: self-checking bench for the advertisement parser, a directed
// table then random BTHome, ATC and noise frames under changing idle and stall patterns
// depends on bsap_pkg and ble_sensor_advert_parser
module tb_ble_sensor_advert_parser;
   import bsap_pkg::*;

   localparam int MAX_FRAME_BYTES = 128;
   localparam int TAB_SIZE        = 73;
   localparam int RAND_ITEMS      = 1550;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 16;

   // object ids in table order, and value length of each
   localparam logic [0:TAB_SIZE-1][7:0] OBJ_ID_TAB = {
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
      8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
      8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
      8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
      8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
      8'h53
   };
   localparam logic [0:TAB_SIZE-1][7:0] OBJ_LEN_TAB = {
      8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3, 8'd2, 8'd2,
      8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd1,
      8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd2, 8'd2, 8'd4, 8'd2, 8'd2, 8'd2, 8'd3,
      8'd2, 8'd2, 8'd2, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2,
      8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd2, 8'd2,
      8'd255
   };
   // table slots of the temperature and humidity objects
   localparam logic [3:0][7:0] VALUE_SLOTS = {8'd58, 8'd46, 8'd3, 8'd2};
   localparam int SLOT_HUM_PCT = 46;
   localparam int SLOT_LAST    = TAB_SIZE - 1;

   // idle percentages per random phase: none, sender, receiver, both
   localparam logic [3:0][7:0] SEND_IDLE = {8'd22, 8'd0, 8'd47, 8'd0};
   localparam logic [3:0][7:0] RECV_IDLE = {8'd22, 8'd47, 8'd0, 8'd0};

   // expected words of the directed frames
   localparam rsp_type EXP_EMPTY = '{1'b0, 20'sd0, 8'd0, 1'b0, 1'b0, KIND_NONE};
   localparam rsp_type EXP_T_MAX = '{1'b1, 20'sd32767, 8'd0, 1'b1, 1'b0, KIND_BTHOME};
   localparam rsp_type EXP_T_MIN = '{1'b1, -20'sd327680, 8'd255, 1'b1, 1'b1, KIND_BTHOME};
   localparam rsp_type EXP_H_0   = '{1'b1, -20'sd327680, 8'd0, 1'b0, 1'b1, KIND_BTHOME};
   localparam rsp_type EXP_KEEP  = '{1'b0, -20'sd327680, 8'd0, 1'b0, 1'b0, KIND_NONE};

   typedef enum logic [1:0] {WALK_ID, WALK_VALUE, WALK_STOP} walk_state_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       last;
      logic       cmd;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int watchdog_cycles;

   rsp_type     frame_reports_q[$];
   logic [7:0]  frame_bytes[$];
   logic        frame_cmd;
   dir_row_type dir_rows[$];

   // parser state mirrored by the predictor
   logic [7:0]         pos;
   logic [7:0]         skip_cnt;
   logic [7:0]         obj_id;
   logic [1:0]         val_idx;
   logic [6:0]         slot;
   logic [7:0]         low_byte;
   walk_state_type     walk;
   logic [7:0]         atc [4];
   logic signed [19:0] temp_pend;
   logic [7:0]         hum_pend;
   logic [1:0]         flags;
   logic signed [19:0] temp_kept;
   logic [7:0]         hum_kept;

   ble_sensor_advert_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hundredths of a percent to whole percent, saturated
   function automatic logic [7:0] centi_to_pct(input logic [15:0] raw);
      logic [15:0] q;
      q = raw / 16'd100;
      return (q > 16'd255) ? 8'hFF : q[7:0];
   endfunction

   // per-frame state back to idle
   task automatic clear_walk();
      pos       = '0;
      skip_cnt  = '0;
      obj_id    = '0;
      val_idx   = '0;
      slot      = '0;
      low_byte  = '0;
      walk      = WALK_ID;
      temp_pend = '0;
      hum_pend  = '0;
      flags     = '0;
   endtask

   // advance the parser by one byte; a report comes out on the last byte of a frame
   task automatic parse_byte(input req_type w, output logic has_rep, output rsp_type rep);
      logic [7:0]         b;
      logic [7:0]         p;
      logic [15:0]        raw;
      logic signed [15:0] raw_s;
      int                 s;
      int                 hit;
      b       = w.data_byte;
      p       = pos;
      has_rep = 1'b0;
      rep     = '0;
      // object walk, only inside the first MAX_FRAME_BYTES bytes
      if (p < MAX_FRAME_BYTES) begin
         if (p == 8'd0) begin
            walk = (b == BTHOME_HEADER) ? WALK_ID : WALK_STOP;
         end else if (walk == WALK_ID) begin
            // ids may repeat but never move back in the table
            hit = -1;
            for (s = int'(slot); s < TAB_SIZE; s++) begin
               if (hit < 0 && OBJ_ID_TAB[s] == b) hit = s;
            end
            if (hit < 0) begin
               walk = WALK_STOP;
            end else begin
               slot     = 7'(hit);
               obj_id   = b;
               skip_cnt = OBJ_LEN_TAB[hit];
               val_idx  = '0;
               walk     = WALK_VALUE;
            end
         end else if (walk == WALK_VALUE) begin
            if (val_idx == 2'd0) low_byte = b;
            if (val_idx < 2'd3) val_idx++;
            if (skip_cnt > 8'd0) skip_cnt--;
            if (skip_cnt == 8'd0) begin
               raw   = {b, low_byte};
               raw_s = raw;
               case (obj_id)
                  OBJ_TEMP_CENTI: begin
                     temp_pend = raw_s;
                     flags[0]  = 1'b1;
                  end
                  OBJ_TEMP_DECI: begin
                     temp_pend = raw_s * 20'sd10;
                     flags[0]  = 1'b1;
                  end
                  OBJ_HUM_CENTI: begin
                     hum_pend = centi_to_pct(raw);
                     flags[1] = 1'b1;
                  end
                  OBJ_HUM_PCT: begin
                     hum_pend = b;
                     flags[1] = 1'b1;
                  end
                  default: ;
               endcase
               walk = WALK_ID;
            end
         end
      end
      // atc field capture runs on every frame
      if (p >= ATC_FIELD_FIRST && p <= ATC_FIELD_LAST) atc[p - ATC_FIELD_FIRST] = b;
      if (pos != POS_MAX) pos++;

      if (w.frame_last) begin
         has_rep = 1'b1;
         if (w.cmd == CMD_BTHOME) begin
            if (flags != 2'd0) begin
               rep.frame_ok         = 1'b1;
               rep.sensor_kind      = KIND_BTHOME;
               rep.temperature_seen = flags[0];
               rep.humidity_seen    = flags[1];
               if (flags[0]) temp_kept = temp_pend;
               if (flags[1]) hum_kept = hum_pend;
            end
         end else if (p == ATC13_LAST_POS || p == ATC15_LAST_POS) begin
            rep.frame_ok         = 1'b1;
            rep.temperature_seen = 1'b1;
            rep.humidity_seen    = 1'b1;
            if (p == ATC13_LAST_POS) begin
               // big-endian tenths, whole percent
               rep.sensor_kind = KIND_ATC13;
               raw_s           = {atc[0], atc[1]};
               temp_kept       = raw_s * 20'sd10;
               hum_kept        = atc[2];
            end else begin
               // little-endian hundredths for both values
               rep.sensor_kind = KIND_ATC15;
               raw_s           = {atc[1], atc[0]};
               temp_kept       = raw_s;
               hum_kept        = centi_to_pct({atc[3], atc[2]});
            end
         end
         rep.temperature_centi = temp_kept;
         rep.humidity_pct      = hum_kept;
         clear_walk();
      end
   endtask

   // value byte with extra weight on sign and range corners
   function automatic logic [7:0] rand_val();
      logic [7:0] v;
      v = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = 8'h7F;
            default: v = 8'h80;
         endcase
      end
      return v;
   endfunction

   // one random frame into frame_bytes and frame_cmd
   task automatic make_frame();
      int pick;
      int n_obj;
      int cur;
      int s;
      int len;
      int k;
      int tail;
      int target;
      pick = $urandom_range(99);
      frame_bytes.delete();
      frame_cmd = CMD_BTHOME;
      if (pick < 45) begin
         // bthome objects in ascending table order
         frame_bytes.push_back(BTHOME_HEADER);
         cur   = 0;
         n_obj = $urandom_range(1, 6);
         for (k = 0; k < n_obj; k++) begin
            if ($urandom_range(99) < 60) begin
               s = VALUE_SLOTS[$urandom_range(3)];
               if (s < cur) s = cur;
            end else begin
               s = cur + $urandom_range(8);
            end
            if (s > SLOT_LAST) s = SLOT_LAST;
            cur = s;
            frame_bytes.push_back(OBJ_ID_TAB[s]);
            len = OBJ_LEN_TAB[s];
            // the open-ended object can never complete
            if (len == 255) len = $urandom_range(20);
            repeat (len) frame_bytes.push_back(rand_val());
         end
         tail = $urandom_range(99);
         if (tail < 10 && frame_bytes.size() > 1) begin
            // cut off the last object
            void'(frame_bytes.pop_back());
         end else if (tail < 20) begin
            // id missing from the table
            case ($urandom_range(2))
               0: frame_bytes.push_back(8'($urandom_range(8'h39, 8'h30)));
               1: frame_bytes.push_back(8'h3B);
               default: frame_bytes.push_back(8'($urandom_range(8'hFF, 8'h54)));
            endcase
            frame_bytes.push_back(rand_val());
         end else if (tail < 30) begin
            // id at or before the current slot
            frame_bytes.push_back(OBJ_ID_TAB[$urandom_range(cur)]);
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_val());
         end
         if ($urandom_range(99) < 5) frame_bytes[0] = BTHOME_HEADER ^ 8'($urandom_range(255, 1));
         if ($urandom_range(9) == 0) frame_cmd = CMD_ATC;
      end else if (pick < 75) begin
         // atc frames of the two valid lengths
         len = (pick < 60) ? 13 : 15;
         repeat (len) frame_bytes.push_back(rand_val());
         frame_cmd = ($urandom_range(9) == 0) ? CMD_BTHOME : CMD_ATC;
      end else if (pick < 85) begin
         // atc frame of a wrong length
         len = $urandom_range(17, 10);
         if (len == 13 || len == 15) len++;
         repeat (len) frame_bytes.push_back(rand_val());
         frame_cmd = CMD_ATC;
      end else if (pick < 98) begin
         // noise
         len = $urandom_range(20, 1);
         repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
         frame_cmd = 1'($urandom_range(1));
      end else begin
         // long bthome frame: humidity objects running up to or past the byte limit
         target = $urandom_range(300, 120);
         frame_bytes.push_back(BTHOME_HEADER);
         if ($urandom_range(1) == 1) begin
            frame_bytes.push_back(OBJ_TEMP_CENTI);
            frame_bytes.push_back(rand_val());
            frame_bytes.push_back(rand_val());
         end
         while (frame_bytes.size() < target) begin
            frame_bytes.push_back(OBJ_ID_TAB[SLOT_HUM_PCT]);
            frame_bytes.push_back(rand_val());
         end
         while (frame_bytes.size() > target) void'(frame_bytes.pop_back());
      end
   endtask

   // offer one word, predict on acceptance
   task automatic feed_byte(input req_type w, input logic use_typed, input rsp_type typed);
      logic    has_rep;
      rsp_type rep;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      parse_byte(w, has_rep, rep);
      if (has_rep) frame_reports_q.push_back(use_typed ? typed : rep);
   endtask

   // hold the sender until every report has come back
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_reports_q.size() != 0);
   endtask

   task automatic cmp_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (frame_reports_q.size() == 0) begin
         $display("%0t: word with no frame pending, expected none got %h", $time, got);
         mismatch_count++;
      end else begin
         want = frame_reports_q.pop_front();
         cmp_field("frame_ok", want.frame_ok, got.frame_ok);
         cmp_field("temperature_centi", $signed(want.temperature_centi),
                   $signed(got.temperature_centi));
         cmp_field("humidity_pct", want.humidity_pct, got.humidity_pct);
         cmp_field("temperature_seen", want.temperature_seen, got.temperature_seen);
         cmp_field("humidity_seen", want.humidity_seen, got.humidity_seen);
         cmp_field("sensor_kind", want.sensor_kind, got.sensor_kind);
      end
   endtask

   // receiver: check each accepted word, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_report(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   initial begin
      for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++) begin
         @(posedge clock);
      end
      $display("tb_ble_sensor_advert_parser: FAIL");
      $finish;
   end

   // stimulus
   initial begin
      req_type w;
      int      ph;
      int      phase_items;
      int      i;
      dir_rows = '{
         // bad header on a one-byte frame, nothing kept yet
         '{8'hFF, 1'b1, CMD_BTHOME, 1'b1, EXP_EMPTY},
         // largest positive hundredths temperature
         '{8'h40, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h02, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'hFF, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h7F, 1'b1, CMD_BTHOME, 1'b1, EXP_T_MAX},
         // hundredths then whole-percent humidity, the later object wins, lowest tenths temperature
         '{8'h40, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h03, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h10, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h27, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h2E, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'hFF, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h45, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h00, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h80, 1'b1, CMD_BTHOME, 1'b1, EXP_T_MIN},
         // backward id stops the walk, humidity before it still counts
         '{8'h40, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h03, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h00, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h00, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h02, 1'b1, CMD_BTHOME, 1'b1, EXP_H_0},
         // unknown id, kept values unchanged
         '{8'h40, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h30, 1'b1, CMD_BTHOME, 1'b1, EXP_KEEP},
         // object cut off by the frame end
         '{8'h40, 1'b0, CMD_BTHOME, 1'b0, EXP_EMPTY},
         '{8'h02, 1'b0, CMD_ATC,    1'b0, EXP_EMPTY},
         '{8'h11, 1'b1, CMD_BTHOME, 1'b1, EXP_KEEP}
      };

      // predictor reset state
      clear_walk();
      temp_kept = '0;
      hum_kept  = '0;
      for (i = 0; i < 4; i++) atc[i] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[r]) begin
         w.data_byte  = dir_rows[r].data_byte;
         w.frame_last = dir_rows[r].last;
         w.cmd        = dir_rows[r].cmd;
         feed_byte(w, dir_rows[r].typed, dir_rows[r].want);
      end
      drain_reports();

      // random frames, one idle pattern per phase
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_IDLE[ph];
         recv_stall_pct = RECV_IDLE[ph];
         phase_items    = 0;
         while (phase_items < RAND_ITEMS / 4) begin
            make_frame();
            foreach (frame_bytes[k]) begin
               w.data_byte  = frame_bytes[k];
               w.frame_last = (k == frame_bytes.size() - 1);
               w.cmd        = w.frame_last ? frame_cmd : 1'($urandom_range(1));
               feed_byte(w, 1'b0, EXP_EMPTY);
            end
            phase_items += frame_bytes.size();
         end
         drain_reports();
      end

      // let any stray word show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_ble_sensor_advert_parser: PASS");
      end else begin
         $display("tb_ble_sensor_advert_parser: FAIL");
      end
      $finish;
   end

endmodule
